### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the filter core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// Types, codes and the micro-op program of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int unsigned FRAC     = 24;
	localparam int unsigned CHUNK    = 16;
	localparam int unsigned CFG_W    = 31;
	localparam int unsigned STEP_W   = 5;

	localparam logic [1:0] CFG_IDX_QA = 2'd0;
	localparam logic [1:0] CFG_IDX_QB = 2'd1;
	localparam logic [1:0] CFG_IDX_RM = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_MRND,
		ST_DIV,
		ST_DFIN
	} state_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11,
		R_Z, R_W, R_DT, R_T, R_DP, R_S, R_Y, R_M,
		R_K0, R_K1, R_QA, R_QB, R_RM
	} reg_id_t;

	typedef struct packed {
		op_t     op;
		reg_id_t a;
		reg_id_t b;
		reg_id_t d;
	} uop_t;

	localparam logic [STEP_W-1:0] LAST_STEP = 5'd29;

	function automatic uop_t mk(input op_t op, input reg_id_t a, input reg_id_t b,
			input reg_id_t d);
		uop_t u;
		u.op = op;
		u.a  = a;
		u.b  = b;
		u.d  = d;
		return u;
	endfunction

	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:    u = mk(OP_SUB, R_W,   R_BIAS, R_T);
			5'd1:    u = mk(OP_MUL, R_DT,  R_T,    R_M);
			5'd2:    u = mk(OP_ADD, R_ANG, R_M,    R_ANG);
			5'd3:    u = mk(OP_MUL, R_DT,  R_P11,  R_DP);
			5'd4:    u = mk(OP_SUB, R_DP,  R_P01,  R_T);
			5'd5:    u = mk(OP_SUB, R_T,   R_P10,  R_T);
			5'd6:    u = mk(OP_ADD, R_T,   R_QA,   R_T);
			5'd7:    u = mk(OP_MUL, R_DT,  R_T,    R_M);
			5'd8:    u = mk(OP_ADD, R_P00, R_M,    R_P00);
			5'd9:    u = mk(OP_SUB, R_P01, R_DP,   R_P01);
			5'd10:   u = mk(OP_SUB, R_P10, R_DP,   R_P10);
			5'd11:   u = mk(OP_MUL, R_QB,  R_DT,   R_M);
			5'd12:   u = mk(OP_ADD, R_P11, R_M,    R_P11);
			5'd13:   u = mk(OP_ADD, R_P00, R_RM,   R_S);
			5'd14:   u = mk(OP_DIV, R_P00, R_S,    R_K0);
			5'd15:   u = mk(OP_DIV, R_P10, R_S,    R_K1);
			5'd16:   u = mk(OP_SUB, R_Z,   R_ANG,  R_Y);
			5'd17:   u = mk(OP_MUL, R_K0,  R_Y,    R_M);
			5'd18:   u = mk(OP_ADD, R_ANG, R_M,    R_ANG);
			5'd19:   u = mk(OP_MUL, R_K1,  R_Y,    R_M);
			5'd20:   u = mk(OP_ADD, R_BIAS, R_M,   R_BIAS);
			5'd21:   u = mk(OP_MUL, R_K1,  R_P00,  R_M);
			5'd22:   u = mk(OP_SUB, R_P10, R_M,    R_P10);
			5'd23:   u = mk(OP_MUL, R_K0,  R_P00,  R_M);
			5'd24:   u = mk(OP_SUB, R_P00, R_M,    R_P00);
			5'd25:   u = mk(OP_MUL, R_K1,  R_P01,  R_M);
			5'd26:   u = mk(OP_SUB, R_P11, R_M,    R_P11);
			5'd27:   u = mk(OP_MUL, R_K0,  R_P01,  R_M);
			5'd28:   u = mk(OP_SUB, R_P01, R_M,    R_P01);
			default: u = mk(OP_OUT, R_ANG, R_ANG,  R_ANG);
		endcase
		return u;
	endfunction

endpackage

### rtl/kabf_ifs.sv
// ----------------------------------------------------------------------------
// kabf channel interfaces
// Valid/ready channels for the filter's input samples and angle results.
// ----------------------------------------------------------------------------
interface kabf_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] measured_angle;
	logic signed [31:0] measured_rate;
	logic        [23:0] time_step;

	modport source (output valid, measured_angle, measured_rate, time_step, input ready);
	modport sink   (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface kabf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] filtered_angle;

	modport source (output valid, filtered_angle, input ready);
	modport sink   (input valid, filtered_angle, output ready);
endinterface

### rtl/kalman_angle_bias_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// Two-state angle/gyro-bias Kalman filter run by a micro-op sequencer over
// one saturating adder, a chunked multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// channel   dir  payload                                   handshake
// in_item   in   measured_angle, measured_rate, time_step  valid/ready
// out_item  out  filtered_angle                            valid/ready
// cfg       in   cfg_index, cfg_data                       cfg_we
//
// Program: 30 micro-ops, two of them divisions; a division whose divisor is not
// positive skips the divider and writes zero. Add/sub and output run in FETCH,
// a multiply in MUL then MRND, a divide in DIV then DFIN.
// Reset clears the estimates and covariance and loads the default noise values.
// in_item.ready is high only in idle; a result waits in the output register
// and the final micro-op holds until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kalman_angle_bias_filter_core #(
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kabf_in_if.sink                         in_item,
	kabf_out_if.source                      out_item,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [kabf_pkg::CFG_W-1:0]      cfg_data
);

	localparam int unsigned W    = WORD_WIDTH;
	localparam int unsigned XW   = W + 1;
	localparam int unsigned NC   = (XW + kabf_pkg::CHUNK - 1) / kabf_pkg::CHUNK;
	localparam int unsigned BW   = NC * kabf_pkg::CHUNK;
	localparam int unsigned PW   = BW + XW;
	localparam int unsigned NB   = W + kabf_pkg::FRAC;
	localparam int unsigned CW   = $clog2(NB + 1);
	localparam int unsigned SATB = (W - 1 > kabf_pkg::FRAC) ? W - 1 : kabf_pkg::FRAC;

	localparam logic signed [63:0] SMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] SMIN64 = -SMAX64 - 64'sd1;
	localparam logic signed [63:0] OMAX64 = 64'sd2147483647;
	localparam logic signed [63:0] OMIN64 = -64'sd2147483648;
	localparam logic [PW-1:0] LIM_P = (PW'(1) << (W - 1)) - PW'(1);
	localparam logic [PW-1:0] LIM_N = PW'(1) << (W - 1);
	localparam logic [PW-1:0] RND   = PW'(1) << (kabf_pkg::FRAC - 1);
	localparam logic [NB-1:0] QSAT  = NB'(1) << SATB;
	localparam logic signed [XW-1:0] SMAX_X = XW'(SMAX64);
	localparam logic signed [XW-1:0] SMIN_X = XW'(SMIN64);

	kabf_pkg::state_t state_q, state_d;
	logic [kabf_pkg::STEP_W-1:0] step_q;
	logic [CW-1:0]               cnt_q;
	logic                        out_valid_q;
	logic signed [31:0]          out_angle_q;

	logic [kabf_pkg::CFG_W-1:0] qa_q, qb_q, rm_q;

	logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [W-1:0] z_q, w_q, dt_q, t_q, dp_q, s_q, y_q, m_q;
	logic signed [XW-1:0] k0_q, k1_q;

	logic          neg_q;
	logic [XW-1:0] ua_q;
	logic [BW-1:0] ub_q;
	logic [PW-1:0] acc_q;
	logic [NB-1:0] dvd_q;
	logic [W-1:0]  den_q;
	logic [W:0]    rem_q;

	kabf_pkg::uop_t      uop;
	logic signed [XW-1:0] opa, opb;
	logic signed [63:0]   sum64;
	logic                 accept;
	logic                 wb_en, step_inc, mul_start, div_start, out_load;
	logic signed [XW-1:0] wb_val;
	logic [XW+15:0]       prod;
	logic [PW-1:0]        rs;
	logic [W:0]           tr;
	logic                 ge;
	logic signed [63:0]   ang64;

	function automatic logic signed [W-1:0] sat_w(input logic signed [63:0] v);
		logic signed [W-1:0] r;
		if (v > SMAX64) r = SMAX64[W-1:0];
		else if (v < SMIN64) r = SMIN64[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	function automatic logic signed [XW-1:0] rd(input kabf_pkg::reg_id_t id);
		logic signed [XW-1:0] r;
		case (id)
			kabf_pkg::R_ANG:  r = XW'(ang_q);
			kabf_pkg::R_BIAS: r = XW'(bias_q);
			kabf_pkg::R_P00:  r = XW'(p00_q);
			kabf_pkg::R_P01:  r = XW'(p01_q);
			kabf_pkg::R_P10:  r = XW'(p10_q);
			kabf_pkg::R_P11:  r = XW'(p11_q);
			kabf_pkg::R_Z:    r = XW'(z_q);
			kabf_pkg::R_W:    r = XW'(w_q);
			kabf_pkg::R_DT:   r = XW'(dt_q);
			kabf_pkg::R_T:    r = XW'(t_q);
			kabf_pkg::R_DP:   r = XW'(dp_q);
			kabf_pkg::R_S:    r = XW'(s_q);
			kabf_pkg::R_Y:    r = XW'(y_q);
			kabf_pkg::R_M:    r = XW'(m_q);
			kabf_pkg::R_K0:   r = k0_q;
			kabf_pkg::R_K1:   r = k1_q;
			kabf_pkg::R_QA:   r = XW'(sat_w(64'(qa_q)));
			kabf_pkg::R_QB:   r = XW'(sat_w(64'(qb_q)));
			kabf_pkg::R_RM:   r = XW'(sat_w(64'(rm_q)));
			default:          r = '0;
		endcase
		return r;
	endfunction

	assign accept         = in_item.valid && in_item.ready;
	assign in_item.ready  = (state_q == kabf_pkg::ST_IDLE);
	assign out_item.valid = out_valid_q;
	assign out_item.filtered_angle = out_angle_q;

	assign uop   = kabf_pkg::uop_at(step_q);
	assign prod  = ua_q * ub_q[BW-1 -: kabf_pkg::CHUNK];
	assign rs    = (acc_q + RND) >> kabf_pkg::FRAC;
	assign tr    = {rem_q[W-1:0], dvd_q[NB-1]};
	assign ge    = (tr >= {1'b0, den_q});
	assign ang64 = 64'(ang_q);

	always_comb begin
		opa = rd(uop.a);
		opb = rd(uop.b);
	end

	always_comb begin
		state_d   = state_q;
		wb_en     = 1'b0;
		wb_val    = '0;
		step_inc  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		sum64     = '0;
		case (state_q)
			kabf_pkg::ST_IDLE: begin
				if (accept) state_d = kabf_pkg::ST_FETCH;
			end
			kabf_pkg::ST_FETCH: begin
				case (uop.op)
					kabf_pkg::OP_ADD, kabf_pkg::OP_SUB: begin
						sum64    = (uop.op == kabf_pkg::OP_ADD) ? 64'(opa) + 64'(opb)
						                                        : 64'(opa) - 64'(opb);
						wb_en    = 1'b1;
						wb_val   = XW'(sat_w(sum64));
						step_inc = 1'b1;
					end
					kabf_pkg::OP_MUL: begin
						mul_start = 1'b1;
						state_d   = kabf_pkg::ST_MUL;
					end
					kabf_pkg::OP_DIV: begin
						if (opb > 0) begin
							div_start = 1'b1;
							state_d   = kabf_pkg::ST_DIV;
						end else begin
							wb_en    = 1'b1;
							step_inc = 1'b1;
						end
					end
					kabf_pkg::OP_OUT: begin
						if (!out_valid_q || out_item.ready) begin
							out_load = 1'b1;
							state_d  = kabf_pkg::ST_IDLE;
						end
					end
					default: state_d = kabf_pkg::ST_IDLE;
				endcase
			end
			kabf_pkg::ST_MUL: begin
				if (cnt_q == CW'(1)) state_d = kabf_pkg::ST_MRND;
			end
			kabf_pkg::ST_MRND: begin
				wb_en    = 1'b1;
				step_inc = 1'b1;
				state_d  = kabf_pkg::ST_FETCH;
				if (rs > (neg_q ? LIM_N : LIM_P)) wb_val = neg_q ? SMIN_X : SMAX_X;
				else wb_val = neg_q ? -XW'(rs) : XW'(rs);
			end
			kabf_pkg::ST_DIV: begin
				if (cnt_q == CW'(1)) state_d = kabf_pkg::ST_DFIN;
			end
			kabf_pkg::ST_DFIN: begin
				wb_en    = 1'b1;
				step_inc = 1'b1;
				state_d  = kabf_pkg::ST_FETCH;
				if (dvd_q >= QSAT) wb_val = neg_q ? SMIN_X : SMAX_X;
				else wb_val = neg_q ? -XW'(dvd_q) : XW'(dvd_q);
			end
			default: state_d = kabf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kabf_pkg::ST_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			qa_q        <= kabf_pkg::CFG_W'(16777);
			qb_q        <= kabf_pkg::CFG_W'(50332);
			rm_q        <= kabf_pkg::CFG_W'(503316);
			ang_q       <= '0;
			bias_q      <= '0;
			p00_q       <= '0;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					kabf_pkg::CFG_IDX_QA: qa_q <= cfg_data;
					kabf_pkg::CFG_IDX_QB: qb_q <= cfg_data;
					kabf_pkg::CFG_IDX_RM: rm_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) step_q <= '0;
			else if (step_inc) step_q <= step_q + 1'b1;
			if (mul_start) cnt_q <= CW'(NC);
			else if (div_start) cnt_q <= CW'(NB);
			else if (state_q == kabf_pkg::ST_MUL || state_q == kabf_pkg::ST_DIV)
				cnt_q <= cnt_q - 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_item.ready) out_valid_q <= 1'b0;
			if (wb_en) begin
				case (uop.d)
					kabf_pkg::R_ANG:  ang_q  <= wb_val[W-1:0];
					kabf_pkg::R_BIAS: bias_q <= wb_val[W-1:0];
					kabf_pkg::R_P00:  p00_q  <= wb_val[W-1:0];
					kabf_pkg::R_P01:  p01_q  <= wb_val[W-1:0];
					kabf_pkg::R_P10:  p10_q  <= wb_val[W-1:0];
					kabf_pkg::R_P11:  p11_q  <= wb_val[W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q  <= sat_w(64'(in_item.measured_angle));
			w_q  <= sat_w(64'(in_item.measured_rate));
			dt_q <= sat_w(64'(in_item.time_step));
		end
		if (wb_en) begin
			case (uop.d)
				kabf_pkg::R_T:  t_q  <= wb_val[W-1:0];
				kabf_pkg::R_DP: dp_q <= wb_val[W-1:0];
				kabf_pkg::R_S:  s_q  <= wb_val[W-1:0];
				kabf_pkg::R_Y:  y_q  <= wb_val[W-1:0];
				kabf_pkg::R_M:  m_q  <= wb_val[W-1:0];
				kabf_pkg::R_K0: k0_q <= wb_val;
				kabf_pkg::R_K1: k1_q <= wb_val;
				default: ;
			endcase
		end
		if (mul_start) begin
			neg_q <= opa[XW-1] ^ opb[XW-1];
			ua_q  <= opa[XW-1] ? XW'(-opa) : XW'(opa);
			ub_q  <= BW'(opb[XW-1] ? XW'(-opb) : XW'(opb));
			acc_q <= '0;
		end else if (state_q == kabf_pkg::ST_MUL) begin
			acc_q <= (acc_q << kabf_pkg::CHUNK) + PW'(prod);
			ub_q  <= ub_q << kabf_pkg::CHUNK;
		end
		if (div_start) begin
			neg_q <= opa[XW-1];
			dvd_q <= {W'(opa[XW-1] ? -opa : opa), {kabf_pkg::FRAC{1'b0}}};
			den_q <= opb[W-1:0];
			rem_q <= '0;
		end else if (state_q == kabf_pkg::ST_DIV) begin
			rem_q <= ge ? tr - {1'b0, den_q} : tr;
			dvd_q <= {dvd_q[NB-2:0], ge};
		end
		if (out_load) begin
			if (ang64 > OMAX64) out_angle_q <= 32'sh7FFFFFFF;
			else if (ang64 < OMIN64) out_angle_q <= 32'sh80000000;
			else out_angle_q <= ang64[31:0];
		end
	end

	`CHK_NEXT(a_accept_starts, accept, state_q == kabf_pkg::ST_FETCH && step_q == '0, "no start")
	`CHK_NOW(a_valid_from_last, $rose(out_valid_q), $past(step_q) == kabf_pkg::LAST_STEP, "early")
	`CHK_NOW(a_round_after_mul, state_q == kabf_pkg::ST_MRND, $past(state_q) == kabf_pkg::ST_MUL, "rnd")
	`CHK_NOW(a_fin_after_div, state_q == kabf_pkg::ST_DFIN, $past(state_q) == kabf_pkg::ST_DIV, "dfin")

endmodule
